// ----- src/jmsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsv_pkg
// Shared constants, error codes, marker codes and the verdict record of the
// marker stream validator.
// ----------------------------------------------------------------------------
package jmsv_pkg;

    localparam int DEF_MAX_COMPONENTS = 3;
    localparam int DEF_MAX_SCANS      = 64;
    localparam int DEF_MAX_MCU_BLOCKS = 10;

    localparam logic [31:0] RST_MAX_STREAM_BYTES = 32'd16777216;
    localparam logic [15:0] RST_DIM_LIMIT        = 16'd16384;
    localparam logic [31:0] RST_PIXEL_LIMIT      = 32'd33554432;

    localparam logic [1:0] REG_MAX_STREAM_BYTES = 2'd0;
    localparam logic [1:0] REG_DIM_LIMIT        = 2'd1;
    localparam logic [1:0] REG_PIXEL_LIMIT      = 2'd2;

    localparam logic [7:0] MRK_SOI  = 8'hd8;
    localparam logic [7:0] MRK_EOI  = 8'hd9;
    localparam logic [7:0] MRK_SOF0 = 8'hc0;
    localparam logic [7:0] MRK_SOF2 = 8'hc2;
    localparam logic [7:0] MRK_DHT  = 8'hc4;
    localparam logic [7:0] MRK_DQT  = 8'hdb;
    localparam logic [7:0] MRK_DRI  = 8'hdd;
    localparam logic [7:0] MRK_SOS  = 8'hda;
    localparam logic [7:0] MRK_COM  = 8'hfe;
    localparam logic [7:0] MRK_RST0 = 8'hd0;
    localparam logic [7:0] MRK_RST7 = 8'hd7;
    localparam logic [7:0] MRK_FILL = 8'hff;

    localparam logic [4:0] ERR_NONE           = 5'd0;
    localparam logic [4:0] ERR_SIZE_OR_SOI    = 5'd1;
    localparam logic [4:0] ERR_DATA_OUTSIDE   = 5'd2;
    localparam logic [4:0] ERR_TRUNC_MARKER   = 5'd3;
    localparam logic [4:0] ERR_BAD_EOI        = 5'd4;
    localparam logic [4:0] ERR_UNSUPPORTED    = 5'd5;
    localparam logic [4:0] ERR_TRUNC_LENGTH   = 5'd6;
    localparam logic [4:0] ERR_BAD_LENGTH     = 5'd7;
    localparam logic [4:0] ERR_BAD_FRAME      = 5'd8;
    localparam logic [4:0] ERR_DIMENSIONS     = 5'd9;
    localparam logic [4:0] ERR_SAMPLING       = 5'd10;
    localparam logic [4:0] ERR_DUPLICATE_ID   = 5'd11;
    localparam logic [4:0] ERR_MCU_LIMIT      = 5'd12;
    localparam logic [4:0] ERR_BAD_SCAN       = 5'd13;
    localparam logic [4:0] ERR_SCAN_LIMIT     = 5'd14;
    localparam logic [4:0] ERR_SCAN_SELECTOR  = 5'd15;
    localparam logic [4:0] ERR_TRUNC_ENTROPY  = 5'd16;
    localparam logic [4:0] ERR_MISSING_EOI    = 5'd17;
    localparam logic [4:0] ERR_MAX            = 5'd17;

    typedef struct packed {
        logic        accepted;
        logic [4:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  component_count;
        logic        is_progressive;
        logic [6:0]  scan_count;
    } verdict_t;

    // Markers that carry a length field and are allowed before EOI.
    function automatic logic is_segment_marker(input logic [7:0] m);
        logic hit;
        hit = (m == MRK_SOF0) || (m == MRK_SOF2) || (m == MRK_DHT) ||
              (m == MRK_DQT) || (m == MRK_DRI) || (m == MRK_SOS) ||
              (m == MRK_COM) || (m inside {[8'he0:8'hef]});
        return hit;
    endfunction

endpackage

// ----- src/jmsv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsv_byte_if / jmsv_verdict_if
// Valid/ready channels for the incoming byte stream and the verdict.
// ----------------------------------------------------------------------------
interface jmsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jmsv_verdict_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [4:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [1:0]  component_count;
    logic        is_progressive;
    logic [6:0]  scan_count;

    modport source (output valid, output accepted, output error_code, output image_width,
                    output image_height, output component_count, output is_progressive,
                    output scan_count, input ready);
    modport sink   (input valid, input accepted, input error_code, input image_width,
                    input image_height, input component_count, input is_progressive,
                    input scan_count, output ready);
endinterface

// ----- src/jpeg_marker_stream_validator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_marker_stream_validator_core
// Checks a JPEG file byte by byte and reports one verdict per file.
// ----------------------------------------------------------------------------
// The stream channel carries one file byte per transfer, with last_byte set
// on the final byte. One byte is taken every cycle while ready is high;
// every byte but the last only updates the parser state and produces nothing.
// The last byte produces exactly one transfer on the verdict channel: the
// pass flag, the first error code and the frame information. The verdict is
// valid in the cycle after the last byte is taken, from an output register.
// While a verdict waits in that register and the receiver stalls, the stream
// side keeps taking bytes of the next file until another last byte arrives;
// that byte waits until the pending verdict is taken.
// Reset empties the output register, clears all parser state and loads the
// limit registers with their defaults. After each last byte the parser
// returns to the start-of-file state by itself.
// Limit registers are written through cfg_write/cfg_index/cfg_data. The user
// must do so only while no file is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
module jpeg_marker_stream_validator_core
    import jmsv_pkg::*;
#(
    parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
    parameter int MAX_SCANS      = DEF_MAX_SCANS,
    parameter int MAX_MCU_BLOCKS = DEF_MAX_MCU_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    jmsv_byte_if.sink       stream,
    jmsv_verdict_if.source  verdict
);

    logic [31:0] max_stream_bytes_reg;
    logic [15:0] dim_limit_reg;
    logic [31:0] pixel_limit_reg;
    logic        can_load;
    logic        take;
    verdict_t    verdict_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_stream_bytes_reg <= RST_MAX_STREAM_BYTES;
            dim_limit_reg        <= RST_DIM_LIMIT;
            pixel_limit_reg      <= RST_PIXEL_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_STREAM_BYTES: max_stream_bytes_reg <= cfg_data;
                REG_DIM_LIMIT:        dim_limit_reg        <= cfg_data[15:0];
                REG_PIXEL_LIMIT:      pixel_limit_reg      <= cfg_data;
                default:              pixel_limit_reg      <= pixel_limit_reg;
            endcase
        end
    end

    // Only a last byte needs room in the output register.
    assign stream.ready = can_load || !stream.last_byte;
    assign take = stream.valid && stream.ready;

    jmsv_parser #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_SCANS      (MAX_SCANS),
        .MAX_MCU_BLOCKS (MAX_MCU_BLOCKS)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .data_byte        (stream.data_byte),
        .last_byte        (stream.last_byte),
        .max_stream_bytes (max_stream_bytes_reg),
        .dim_limit        (dim_limit_reg),
        .pixel_limit      (pixel_limit_reg),
        .verdict          (verdict_now)
    );

    jmsv_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && stream.last_byte),
        .verdict_in (verdict_now),
        .can_load   (can_load),
        .verdict    (verdict)
    );

    a_pass_flag: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (verdict.accepted == (verdict.error_code == ERR_NONE)))
        else $error("pass flag disagrees with error code");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict.valid && !verdict.accepted) |->
        (verdict.image_width == 16'd0 && verdict.image_height == 16'd0 &&
         verdict.component_count == 2'd0 && !verdict.is_progressive &&
         verdict.scan_count == 7'd0))
        else $error("rejected verdict carries frame data");

    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (stream.valid && stream.ready && stream.last_byte) |=> verdict.valid)
        else $error("last byte did not produce a verdict");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (verdict.error_code <= ERR_MAX))
        else $error("error code out of range");

endmodule

// ----- src/jmsv_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsv_parser
// Per-byte marker and segment parser. Holds the whole stream state and
// produces the verdict for the byte being taken when it is the last one.
// ----------------------------------------------------------------------------
module jmsv_parser
    import jmsv_pkg::*;
#(
    parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
    parameter int MAX_SCANS      = DEF_MAX_SCANS,
    parameter int MAX_MCU_BLOCKS = DEF_MAX_MCU_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] max_stream_bytes,
    input  logic [15:0] dim_limit,
    input  logic [31:0] pixel_limit,
    output verdict_t    verdict
);

    localparam int CW = $clog2(MAX_COMPONENTS + 1);
    localparam int MW = $clog2(16 * MAX_COMPONENTS + 1);

    localparam logic [3:0] PH_SOI0       = 4'd0;
    localparam logic [3:0] PH_SOI1       = 4'd1;
    localparam logic [3:0] PH_MARK       = 4'd2;
    localparam logic [3:0] PH_FILL       = 4'd3;
    localparam logic [3:0] PH_LEN_HI     = 4'd4;
    localparam logic [3:0] PH_LEN_LO     = 4'd5;
    localparam logic [3:0] PH_PAYLOAD    = 4'd6;
    localparam logic [3:0] PH_ENTROPY    = 4'd7;
    localparam logic [3:0] PH_ENTROPY_FF = 4'd8;
    localparam logic [3:0] PH_HALT       = 4'd9;
    localparam logic [3:0] PH_DONE       = 4'd10;

    logic [31:0] pos_reg, pos_next;
    logic        over_reg, over_next;
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] seglen_reg, seglen_next;
    logic [15:0] offset_reg, offset_next;
    logic [CW-1:0] comp_idx_reg, comp_idx_next;
    logic [1:0]  comp_sub_reg, comp_sub_next;
    logic        frame_seen_reg, frame_seen_next;
    logic [6:0]  scans_reg, scans_next;
    logic [7:0]  ids_reg [MAX_COMPONENTS];
    logic [7:0]  ids_next [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] mask_reg, mask_next;
    logic [CW-1:0] total_reg, total_next;
    logic [MW-1:0] mcu_reg, mcu_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [CW-1:0] comps_reg, comps_next;
    logic        prog_reg, prog_next;
    logic [4:0]  err_reg, err_next;
    logic [31:0] pixels_reg, pixels_next;

    always_comb
    begin
        logic [4:0]  raise;
        logic [15:0] len;
        logic [15:0] plen;
        logic [16:0] o_inc;
        logic [3:0]  hs;
        logic [3:0]  vs;
        logic        dup;
        logic [MAX_COMPONENTS-1:0] bit_sel;
        logic        is_frame;
        logic [4:0]  code;

        raise = ERR_NONE;
        len = {seglen_reg[7:0], data_byte};
        plen = seglen_reg - 16'd2;
        o_inc = {1'b0, offset_reg} + 17'd1;
        hs = data_byte[7:4];
        vs = data_byte[3:0];
        dup = 1'b0;
        bit_sel = '0;
        is_frame = (marker_reg == MRK_SOF0) || (marker_reg == MRK_SOF2);
        code = ERR_NONE;

        over_next = over_reg;
        pos_next = pos_reg;
        phase_next = phase_reg;
        marker_next = marker_reg;
        seglen_next = seglen_reg;
        offset_next = offset_reg;
        comp_idx_next = comp_idx_reg;
        comp_sub_next = comp_sub_reg;
        frame_seen_next = frame_seen_reg;
        scans_next = scans_reg;
        ids_next = ids_reg;
        mask_next = mask_reg;
        total_next = total_reg;
        mcu_next = mcu_reg;
        width_next = width_reg;
        height_next = height_reg;
        comps_next = comps_reg;
        prog_next = prog_reg;
        err_next = err_reg;
        pixels_next = pixels_reg;

        if (pos_reg == 32'hffff_ffff)
            over_next = 1'b1;
        else
            pos_next = pos_reg + 32'd1;

        case (phase_reg)
            PH_SOI0:
            begin
                if (data_byte != MRK_FILL) raise = ERR_SIZE_OR_SOI;
                else phase_next = PH_SOI1;
            end
            PH_SOI1:
            begin
                if (data_byte != MRK_SOI) raise = ERR_SIZE_OR_SOI;
                else phase_next = PH_MARK;
            end
            PH_MARK:
            begin
                if (data_byte != MRK_FILL) raise = ERR_DATA_OUTSIDE;
                else phase_next = PH_FILL;
            end
            PH_FILL, PH_ENTROPY_FF:
            begin
                if (data_byte == MRK_FILL)
                begin
                    phase_next = phase_reg;
                end
                else if (phase_reg == PH_ENTROPY_FF && (data_byte == 8'h00 ||
                         data_byte inside {[MRK_RST0:MRK_RST7]}))
                begin
                    phase_next = PH_ENTROPY;
                end
                else
                begin
                    marker_next = data_byte;
                    if (data_byte == MRK_EOI)
                    begin
                        if (frame_seen_reg && scans_reg != 7'd0 && last_byte)
                            phase_next = PH_DONE;
                        else
                            raise = ERR_BAD_EOI;
                    end
                    else if (!is_segment_marker(data_byte))
                        raise = ERR_UNSUPPORTED;
                    else
                        phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                seglen_next = {8'd0, data_byte};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                seglen_next = len;
                plen = len - 16'd2;
                if (len < 16'd2)
                    raise = ERR_BAD_LENGTH;
                else if (is_frame && (frame_seen_reg || plen < 16'd6))
                    raise = ERR_BAD_FRAME;
                else if (marker_reg == MRK_SOS && (!frame_seen_reg || plen < 16'd1))
                    raise = ERR_BAD_SCAN;
                else
                begin
                    if (is_frame) mcu_next = '0;
                    if (marker_reg == MRK_SOS) mask_next = '0;
                    offset_next = '0;
                    comp_idx_next = '0;
                    comp_sub_next = 2'd0;
                    if (plen == 16'd0)
                        phase_next = (marker_reg == MRK_SOS) ? PH_ENTROPY : PH_MARK;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                if (is_frame)
                begin
                    case (offset_reg)
                        16'd0: if (data_byte != 8'd8) raise = ERR_BAD_FRAME;
                        16'd1: height_next = {data_byte, 8'd0};
                        16'd2: height_next = {height_reg[15:8], data_byte};
                        16'd3: width_next = {data_byte, 8'd0};
                        16'd4:
                        begin
                            width_next = {width_reg[15:8], data_byte};
                            pixels_next = {width_reg[15:8], data_byte} * height_reg;
                        end
                        16'd5:
                        begin
                            if (!(data_byte == 8'd1 || data_byte == 8'd3) ||
                                data_byte > 8'(MAX_COMPONENTS) ||
                                {1'b0, plen} != 17'd6 + 17'd3 * {9'd0, data_byte})
                                raise = ERR_BAD_FRAME;
                            else
                            begin
                                comps_next = CW'(data_byte);
                                if (width_reg == 16'd0 || height_reg == 16'd0 ||
                                    width_reg > dim_limit ||
                                    height_reg > dim_limit ||
                                    pixels_reg > pixel_limit)
                                    raise = ERR_DIMENSIONS;
                            end
                        end
                        default:
                        begin
                            if (int'(comp_idx_reg) < MAX_COMPONENTS)
                            begin
                                case (comp_sub_reg)
                                    2'd0:
                                    begin
                                        for (int k = 0; k < MAX_COMPONENTS; k++)
                                            if (int'(comp_idx_reg) == k)
                                                ids_next[k] = data_byte;
                                    end
                                    2'd1:
                                    begin
                                        if (hs == 4'd0 || hs > 4'd4 || vs == 4'd0 ||
                                            vs > 4'd4)
                                            raise = ERR_SAMPLING;
                                        else
                                            mcu_next = mcu_reg + MW'(hs) * MW'(vs);
                                    end
                                    default:
                                    begin
                                        for (int k = 0; k < MAX_COMPONENTS; k++)
                                            for (int j = 0; j < MAX_COMPONENTS; j++)
                                                if (j < k && int'(comp_idx_reg) == k &&
                                                    ids_reg[j] == ids_reg[k])
                                                    dup = 1'b1;
                                        if (data_byte > 8'd3) raise = ERR_SAMPLING;
                                        else if (dup) raise = ERR_DUPLICATE_ID;
                                    end
                                endcase
                            end
                            // Walk the three bytes of each component entry.
                            if (comp_sub_reg == 2'd2)
                            begin
                                comp_sub_next = 2'd0;
                                if (int'(comp_idx_reg) < MAX_COMPONENTS)
                                    comp_idx_next = comp_idx_reg + CW'(1);
                            end
                            else
                                comp_sub_next = comp_sub_reg + 2'd1;
                        end
                    endcase
                end
                else if (marker_reg == MRK_SOS)
                begin
                    if (offset_reg == 16'd0)
                    begin
                        if (data_byte == 8'd0 || data_byte > 8'(comps_reg) ||
                            {1'b0, plen} != 17'd4 + 17'd2 * {9'd0, data_byte})
                            raise = ERR_BAD_SCAN;
                        else if (scans_reg >= 7'(MAX_SCANS))
                            raise = ERR_SCAN_LIMIT;
                        else
                        begin
                            scans_next = scans_reg + 7'd1;
                            total_next = CW'(data_byte);
                            mask_next = '0;
                        end
                    end
                    else if (offset_reg[0] &&
                             ((offset_reg - 16'd1) >> 1) < 16'(total_reg))
                    begin
                        for (int j = 0; j < MAX_COMPONENTS; j++)
                            if (j < int'(comps_reg) && ids_reg[j] == data_byte)
                                bit_sel = MAX_COMPONENTS'(1) << j;
                        if (bit_sel == '0 || (mask_reg & bit_sel) != '0)
                            raise = ERR_SCAN_SELECTOR;
                        else
                            mask_next = mask_reg | bit_sel;
                    end
                end
                if (raise == ERR_NONE)
                begin
                    offset_next = o_inc[15:0];
                    if (o_inc >= {1'b0, plen})
                    begin
                        if (is_frame && 8'(mcu_next) > 8'(MAX_MCU_BLOCKS))
                            raise = ERR_MCU_LIMIT;
                        else
                        begin
                            if (is_frame)
                            begin
                                frame_seen_next = 1'b1;
                                prog_next = (marker_reg == MRK_SOF2);
                            end
                            phase_next = (marker_reg == MRK_SOS) ? PH_ENTROPY : PH_MARK;
                        end
                    end
                end
            end
            PH_ENTROPY:
            begin
                if (data_byte == MRK_FILL) phase_next = PH_ENTROPY_FF;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (raise != ERR_NONE)
        begin
            if (err_reg == ERR_NONE) err_next = raise;
            phase_next = PH_HALT;
        end

        if (over_next || pos_next < 32'd4 || pos_next > max_stream_bytes ||
            dim_limit == 16'd0 || pixel_limit == 32'd0)
            code = ERR_SIZE_OR_SOI;
        else if (err_next != ERR_NONE)
            code = err_next;
        else
        begin
            case (phase_next)
                PH_DONE:                code = ERR_NONE;
                PH_FILL:                code = ERR_TRUNC_MARKER;
                PH_LEN_HI, PH_LEN_LO:   code = ERR_TRUNC_LENGTH;
                PH_PAYLOAD:             code = ERR_BAD_LENGTH;
                PH_ENTROPY_FF:          code = ERR_TRUNC_ENTROPY;
                PH_MARK, PH_ENTROPY:    code = ERR_MISSING_EOI;
                default:                code = ERR_SIZE_OR_SOI;
            endcase
        end

        verdict.accepted        = (code == ERR_NONE);
        verdict.error_code      = code;
        verdict.image_width     = (code == ERR_NONE) ? width_next : 16'd0;
        verdict.image_height    = (code == ERR_NONE) ? height_next : 16'd0;
        verdict.component_count = (code == ERR_NONE) ? 2'(comps_next) : 2'd0;
        verdict.is_progressive  = (code == ERR_NONE) && prog_next;
        verdict.scan_count      = (code == ERR_NONE) ? scans_next : 7'd0;
    end

    // The last byte returns every piece of stream state to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            over_reg       <= 1'b0;
            phase_reg      <= PH_SOI0;
            marker_reg     <= '0;
            seglen_reg     <= '0;
            offset_reg     <= '0;
            comp_idx_reg   <= '0;
            comp_sub_reg   <= '0;
            frame_seen_reg <= 1'b0;
            scans_reg      <= '0;
            ids_reg        <= '{default: '0};
            mask_reg       <= '0;
            total_reg      <= '0;
            mcu_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            comps_reg      <= '0;
            prog_reg       <= 1'b0;
            err_reg        <= '0;
            pixels_reg     <= '0;
        end
        else if (take && last_byte)
        begin
            pos_reg        <= '0;
            over_reg       <= 1'b0;
            phase_reg      <= PH_SOI0;
            marker_reg     <= '0;
            seglen_reg     <= '0;
            offset_reg     <= '0;
            comp_idx_reg   <= '0;
            comp_sub_reg   <= '0;
            frame_seen_reg <= 1'b0;
            scans_reg      <= '0;
            ids_reg        <= '{default: '0};
            mask_reg       <= '0;
            total_reg      <= '0;
            mcu_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            comps_reg      <= '0;
            prog_reg       <= 1'b0;
            err_reg        <= '0;
            pixels_reg     <= '0;
        end
        else if (take)
        begin
            pos_reg        <= pos_next;
            over_reg       <= over_next;
            phase_reg      <= phase_next;
            marker_reg     <= marker_next;
            seglen_reg     <= seglen_next;
            offset_reg     <= offset_next;
            comp_idx_reg   <= comp_idx_next;
            comp_sub_reg   <= comp_sub_next;
            frame_seen_reg <= frame_seen_next;
            scans_reg      <= scans_next;
            ids_reg        <= ids_next;
            mask_reg       <= mask_next;
            total_reg      <= total_next;
            mcu_reg        <= mcu_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            comps_reg      <= comps_next;
            prog_reg       <= prog_next;
            err_reg        <= err_next;
            pixels_reg     <= pixels_next;
        end
    end

endmodule

// ----- src/jmsv_result_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmsv_result_reg
// Output register for the verdict channel. Holds a verdict until its
// transfer completes.
// ----------------------------------------------------------------------------
module jmsv_result_reg
    import jmsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  verdict_t verdict_in,
    output logic     can_load,
    jmsv_verdict_if.source verdict
);

    logic     valid_reg;
    verdict_t data_reg;

    assign can_load = !valid_reg || verdict.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (verdict.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= verdict_in;
    end

    assign verdict.valid           = valid_reg;
    assign verdict.accepted        = data_reg.accepted;
    assign verdict.error_code      = data_reg.error_code;
    assign verdict.image_width     = data_reg.image_width;
    assign verdict.image_height    = data_reg.image_height;
    assign verdict.component_count = data_reg.component_count;
    assign verdict.is_progressive  = data_reg.is_progressive;
    assign verdict.scan_count      = data_reg.scan_count;

endmodule
